>>> hw/rtl/angle_frame_parser_assert.svh
// Assertion shorthands shared by the checker.
`ifndef ANGLE_FRAME_PARSER_ASSERT_SVH
`define ANGLE_FRAME_PARSER_ASSERT_SVH

// Plain property, checked out of reset.
`define AFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define AFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/afp_pkg.sv
`timescale 1ns / 1ps
package afp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [7:0] TYPE_RESET   = 8'h53;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TYPE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RESYNC,
    ST_REPORT
  } afp_state_e;

  // Control from the sequencer to the cell row.
  typedef struct packed {
    logic       shift;
    logic       load;
    logic [7:0] load_data;
  } seq_ctrl_t;

  // Frame completion event toward the result register.
  typedef struct packed {
    logic fire;
    logic bad;
  } seq_evt_t;

endpackage

>>> hw/rtl/afp_cell.sv
`timescale 1ns / 1ps
module afp_cell (
  input  logic              clk_i,
  input  afp_pkg::cell_op_e op_i,
  input  logic [7:0]        load_data_i,
  input  logic [7:0]        shift_data_i,
  output logic [7:0]        data_o
);
  import afp_pkg::*;

  logic [7:0] data_d, data_q;

  always_comb begin
    case (op_i)
      CELL_LOAD:  data_d = load_data_i;
      CELL_SHIFT: data_d = shift_data_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/afp_seq.sv
`timescale 1ns / 1ps
module afp_seq #(
  parameter int FrameLen = afp_pkg::FRAME_LEN,
  parameter int FillW    = $clog2(FrameLen)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         header_i,
  input  logic [7:0]         type_i,
  input  logic [7:0]         head0_i,
  input  logic [7:0]         head1_i,
  input  logic               out_free_i,
  output logic               in_ready_o,
  output afp_pkg::seq_ctrl_t ctrl_o,
  output logic [FillW-1:0]   load_idx_o,
  output afp_pkg::seq_evt_t  evt_o
);
  import afp_pkg::*;

  localparam logic [FillW-1:0] LastIdx = FillW'(FrameLen - 1);
  localparam logic [FillW-1:0] ScanEnd = FillW'(FrameLen - 2);
  localparam logic [FillW-1:0] LenMod  = FillW'(FrameLen);

  afp_state_e       state_d, state_q;
  logic [FillW-1:0] fill_d, fill_q;
  logic [FillW-1:0] step_d, step_q;
  logic [7:0]       acc_d, acc_q;
  logic             good_d, good_q;

  logic in_fire;
  logic sum_ok;
  logic pair_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // cell 0 carries the checksum byte on the last rotation step
  assign sum_ok     = (acc_q == head0_i);
  assign pair_hit   = (step_q != '0) && (head0_i == header_i) && (head1_i == type_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && fill_q == LastIdx) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (step_q == LastIdx) state_d = sum_ok ? ST_REPORT : ST_RESYNC;
      end
      ST_RESYNC: begin
        if (pair_hit || step_q == ScanEnd) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cell control and events
  always_comb begin
    ctrl_o     = '0;
    load_idx_o = '0;
    evt_o      = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.load_data = rx_byte_i;
        if (in_fire) begin
          load_idx_o = fill_q;
          case (fill_q)
            FillW'(0): ctrl_o.load = (rx_byte_i == header_i);
            FillW'(1): ctrl_o.load = (rx_byte_i == type_i);
            default:   ctrl_o.load = 1'b1;
          endcase
        end
      end
      ST_CHECK: begin
        ctrl_o.shift = 1'b1;
      end
      ST_RESYNC: begin
        ctrl_o.load_data = header_i;
        if (!pair_hit) begin
          if (step_q == ScanEnd) begin
            // the old last byte sits in cell 1 here; keep it as a lone header
            ctrl_o.load = (head1_i == header_i);
          end else begin
            ctrl_o.shift = 1'b1;
          end
        end
      end
      ST_REPORT: begin
        evt_o.fire = out_free_i;
        evt_o.bad  = !good_q;
      end
      default: ;
    endcase
  end

  // fill, step and checksum
  always_comb begin
    fill_d = fill_q;
    step_d = step_q;
    acc_d  = acc_q;
    good_d = good_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (fill_q)
            FillW'(0): begin
              if (rx_byte_i == header_i) fill_d = FillW'(1);
            end
            FillW'(1): begin
              if (rx_byte_i == type_i) begin
                fill_d = FillW'(2);
              end else if (rx_byte_i != header_i) begin
                fill_d = '0;
              end
            end
            default: begin
              if (fill_q == LastIdx) begin
                fill_d = '0;
                step_d = '0;
                acc_d  = '0;
              end else begin
                fill_d = fill_q + FillW'(1);
              end
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (step_q == LastIdx) begin
          good_d = sum_ok;
          step_d = '0;
        end else begin
          acc_d  = acc_q + head0_i;
          step_d = step_q + FillW'(1);
        end
      end
      ST_RESYNC: begin
        if (pair_hit) begin
          fill_d = LenMod - step_q;
        end else if (step_q == ScanEnd) begin
          fill_d = (head1_i == header_i) ? FillW'(1) : '0;
        end else begin
          step_d = step_q + FillW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      step_q  <= '0;
      acc_q   <= '0;
      good_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
      good_q  <= good_d;
    end
  end

endmodule

>>> hw/rtl/angle_frame_parser.sv
`timescale 1ns / 1ps
// Serial angle-frame parser. Each received byte is one input transaction; a byte
// that does not finish a frame leaves the input ready for the next byte. The byte
// that finishes a FrameLen-byte frame starts a checksum pass that rotates the
// frame once around the row of byte cells, then on a checksum error one-place
// shifts to find the next header/type pair, then posts the result, held back while
// the previous result has not been taken. The input stays blocked from that byte
// until the result is posted. A result appears only when a frame ends; status 0
// means the angles were latched, 1 means a checksum error. Angle, counter and
// valid outputs hold the latest state between results.
// Configuration writes (index 0 header byte, 1 frame type) are always ready.
module angle_frame_parser #(
  parameter int FrameLen = afp_pkg::FRAME_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           status_o,
  output logic signed [15:0]             angle_roll_o,
  output logic signed [15:0]             angle_pitch_o,
  output logic signed [15:0]             angle_yaw_o,
  output logic [31:0]                    good_frames_o,
  output logic [31:0]                    bad_frames_o,
  output logic                           angles_valid_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import afp_pkg::*;

  localparam int FillW = $clog2(FrameLen);

  logic [7:0] header_q, type_q;
  logic [7:0] cells [FrameLen];

  seq_ctrl_t        ctrl;
  seq_evt_t         evt;
  logic [FillW-1:0] load_idx;
  logic             out_free;

  logic               out_valid_q, status_q, seen_q;
  logic signed [15:0] roll_q, pitch_q, yaw_q;
  logic [31:0]        good_q, bad_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      type_q   <= TYPE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEADER: header_q <= cfg_data_i;
        CFG_TYPE:   type_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte cells: shifting rotates toward cell 0
  for (genvar i = 0; i < FrameLen; i++) begin : g_cell
    localparam int Nxt = (i + 1) % FrameLen;
    cell_op_e op;

    assign op = ctrl.shift ? CELL_SHIFT :
                (ctrl.load && load_idx == FillW'(i)) ? CELL_LOAD : CELL_HOLD;

    afp_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .load_data_i  (ctrl.load_data),
      .shift_data_i (cells[Nxt]),
      .data_o       (cells[i])
    );
  end

  assign out_free = !out_valid_q || out_ready_i;

  afp_seq #(
    .FrameLen (FrameLen),
    .FillW    (FillW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .header_i   (header_q),
    .type_i     (type_q),
    .head0_i    (cells[0]),
    .head1_i    (cells[1]),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .load_idx_o (load_idx),
    .evt_o      (evt)
  );

  // result register; angles and counters double as the held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      seen_q      <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      good_q      <= '0;
      bad_q       <= '0;
    end else if (evt.fire) begin
      out_valid_q <= 1'b1;
      status_q    <= evt.bad;
      if (evt.bad) begin
        bad_q <= bad_q + 32'd1;
      end else begin
        roll_q  <= $signed({cells[3], cells[2]});
        pitch_q <= $signed({cells[5], cells[4]});
        yaw_q   <= $signed({cells[7], cells[6]});
        good_q  <= good_q + 32'd1;
        seen_q  <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign angle_roll_o   = roll_q;
  assign angle_pitch_o  = pitch_q;
  assign angle_yaw_o    = yaw_q;
  assign good_frames_o  = good_q;
  assign bad_frames_o   = bad_q;
  assign angles_valid_o = seen_q;

endmodule

>>> hw/rtl/afp_checker.sv
`timescale 1ns / 1ps
`include "angle_frame_parser_assert.svh"
module afp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic [31:0] good_frames_i,
  input logic [31:0] bad_frames_i,
  input logic        angles_valid_i
);

  `AFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped before transaction")
  `AFP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(status_i) && $stable(good_frames_i) && $stable(bad_frames_i), "stalled result changed")
  `AFP_ASSERT_IMPL(a_good_sets_valid, clk_i, rst_ni, out_valid_i && !status_i, angles_valid_i, "good frame without angles valid")
  `AFP_ASSERT(a_valid_sticky, clk_i, rst_ni, !$fell(angles_valid_i), "angles valid cleared")

endmodule

bind angle_frame_parser afp_checker u_afp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_i       (status_o),
  .good_frames_i  (good_frames_o),
  .bad_frames_i   (bad_frames_o),
  .angles_valid_i (angles_valid_o)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import afp_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 2 * FRAME_LEN + 8;

  // Indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_RESYNC,
    FRAME_BAD_TRAIL
  } frame_kind_e;

  typedef struct {
    logic               status;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [31:0]        good;
    logic [31:0]        bad;
    logic               valid;
  } frame_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           rx_byte_i = 8'h00;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 status_o;
  logic signed [15:0]   angle_roll_o;
  logic signed [15:0]   angle_pitch_o;
  logic signed [15:0]   angle_yaw_o;
  logic [31:0]          good_frames_o;
  logic [31:0]          bad_frames_o;
  logic                 angles_valid_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_HEADER;
  logic [7:0]           cfg_data_i = 8'h00;

  angle_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .angle_roll_o  (angle_roll_o),
    .angle_pitch_o (angle_pitch_o),
    .angle_yaw_o   (angle_yaw_o),
    .good_frames_o (good_frames_o),
    .bad_frames_o  (bad_frames_o),
    .angles_valid_o(angles_valid_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored on the testbench side.
  logic [7:0]         hdr_cfg;
  logic [7:0]         type_cfg;
  logic [7:0]         frame_bytes [FRAME_LEN];
  int                 bytes_held;
  logic signed [15:0] held_roll;
  logic signed [15:0] held_pitch;
  logic signed [15:0] held_yaw;
  logic [31:0]        good_total;
  logic [31:0]        bad_total;
  logic               angles_seen;

  logic [7:0]    pending_bytes [$];
  frame_result_t results_due [$];
  frame_result_t pred_res;
  int            queued_total;
  int            mismatches;
  int            cycle_count;
  int            burst_left;
  int            gap_left;
  int            stall_mode;
  int            stall_left;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 'h%0h, expected 'h%0h", name, got, want));
  endtask

  // Search for the earliest header/type pair and shift it down; else keep a
  // trailing header; else restart the hunt.
  function automatic void resync_frame();
    int pos;
    pos = -1;
    for (int p = 1; p <= FRAME_LEN - 2; p++)
      if (pos < 0 && frame_bytes[p] == hdr_cfg && frame_bytes[p+1] == type_cfg)
        pos = p;
    if (pos >= 0) begin
      for (int i = 0; i < FRAME_LEN - pos; i++)
        frame_bytes[i] = frame_bytes[pos+i];
      bytes_held = FRAME_LEN - pos;
    end else if (frame_bytes[FRAME_LEN-1] == hdr_cfg) begin
      frame_bytes[0] = hdr_cfg;
      bytes_held = 1;
    end else begin
      bytes_held = 0;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    logic [7:0] acc;
    r = '{default: '0};
    if (bytes_held == 0) begin
      if (b == hdr_cfg) begin
        frame_bytes[0] = b;
        bytes_held = 1;
      end
      return 1'b0;
    end
    if (bytes_held == 1) begin
      // Type wins over a repeated header when both registers match.
      if (b == type_cfg) begin
        frame_bytes[1] = b;
        bytes_held = 2;
      end else if (b != hdr_cfg) begin
        bytes_held = 0;
      end
      return 1'b0;
    end
    frame_bytes[bytes_held] = b;
    bytes_held++;
    if (bytes_held < FRAME_LEN)
      return 1'b0;
    acc = 8'h00;
    for (int i = 0; i < FRAME_LEN - 1; i++)
      acc += frame_bytes[i];
    if (acc == frame_bytes[FRAME_LEN-1]) begin
      bytes_held  = 0;
      held_roll   = {frame_bytes[3], frame_bytes[2]};
      held_pitch  = {frame_bytes[5], frame_bytes[4]};
      held_yaw    = {frame_bytes[7], frame_bytes[6]};
      good_total  = good_total + 32'd1;
      angles_seen = 1'b1;
      r.status    = 1'b0;
    end else begin
      bad_total = bad_total + 32'd1;
      resync_frame();
      r.status = 1'b1;
    end
    r.roll  = held_roll;
    r.pitch = held_pitch;
    r.yaw   = held_yaw;
    r.good  = good_total;
    r.bad   = bad_total;
    r.valid = angles_seen;
    return 1'b1;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  function automatic logic [15:0] rand_angle();
    logic [15:0] corners [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(0, 7) == 0)
      return corners[$urandom_range(0, 3)];
    return 16'($urandom());
  endfunction

  // Build one frame from the current header/type; pair_at places a
  // header/type pair inside a bad frame for the resync search.
  task automatic queue_frame(input frame_kind_e kind, input logic [15:0] roll,
                             input logic [15:0] pitch, input logic [15:0] yaw,
                             input int pair_at);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] acc;
    fr[0] = hdr_cfg;
    fr[1] = type_cfg;
    fr[2] = roll[7:0];
    fr[3] = roll[15:8];
    fr[4] = pitch[7:0];
    fr[5] = pitch[15:8];
    fr[6] = yaw[7:0];
    fr[7] = yaw[15:8];
    for (int i = 8; i < FRAME_LEN - 1; i++)
      fr[i] = 8'($urandom());
    if (kind == FRAME_BAD_RESYNC) begin
      fr[pair_at]   = hdr_cfg;
      fr[pair_at+1] = type_cfg;
    end
    acc = 8'h00;
    for (int i = 0; i < FRAME_LEN - 1; i++)
      acc += fr[i];
    if (kind == FRAME_BAD_TRAIL && acc == hdr_cfg) begin
      fr[FRAME_LEN-2] += 8'd1;
      acc += 8'd1;
    end
    case (kind)
      FRAME_GOOD:      fr[FRAME_LEN-1] = acc;
      FRAME_BAD_TRAIL: fr[FRAME_LEN-1] = hdr_cfg;
      default:         fr[FRAME_LEN-1] = acc ^ 8'($urandom_range(1, 255));
    endcase
    for (int i = 0; i < FRAME_LEN; i++)
      queue_byte(fr[i]);
  endtask

  // Mostly well-formed frames, with bad sums, resync bait, repeated and
  // broken headers, truncated frames and line noise mixed in.
  task automatic queue_random(input int count);
    int stop_at;
    int pick;
    int cut;
    stop_at = queued_total + count;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_frame(FRAME_GOOD, rand_angle(), rand_angle(), rand_angle(), 0);
      end else if (pick < 65) begin
        queue_frame(FRAME_BAD_SUM, rand_angle(), rand_angle(), rand_angle(), 0);
      end else if (pick < 73) begin
        queue_frame(FRAME_BAD_RESYNC, rand_angle(), rand_angle(), rand_angle(),
                    $urandom_range(2, FRAME_LEN - 3));
      end else if (pick < 78) begin
        queue_frame(FRAME_BAD_TRAIL, rand_angle(), rand_angle(), rand_angle(), 0);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 3)) queue_byte(hdr_cfg);
        queue_frame(FRAME_GOOD, rand_angle(), rand_angle(), rand_angle(), 0);
      end else if (pick < 89) begin
        queue_byte(hdr_cfg);
        queue_byte(8'($urandom()));
      end else if (pick < 94) begin
        cut = $urandom_range(1, FRAME_LEN - 1);
        queue_byte(hdr_cfg);
        queue_byte(type_cfg);
        repeat (cut) queue_byte(8'($urandom()));
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom()));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_HEADER: hdr_cfg = val;
      CFG_TYPE:   type_cfg = val;
      default:    ;
    endcase
  endtask

  // Hold off until every byte is in and every result is out, then let a
  // byte that completes nothing finish inside the block.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [7:0] hdr, input logic [7:0] typ,
                             input int count);
    wait_drained();
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_TYPE, typ);
    @(negedge clk_i);
    queue_random(count);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switch between always ready, coin flips and sparse readiness.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(50, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Predict on every accepted byte, then check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        if (parse_byte(rx_byte_i, pred_res))
          results_due.push_back(pred_res);
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transaction with no frame outstanding");
        end else begin
          pred_res = results_due.pop_front();
          check_field("status", 32'(status_o), 32'(pred_res.status));
          check_field("angle_roll", 32'(angle_roll_o), 32'(pred_res.roll));
          check_field("angle_pitch", 32'(angle_pitch_o), 32'(pred_res.pitch));
          check_field("angle_yaw", 32'(angle_yaw_o), 32'(pred_res.yaw));
          check_field("good_frames", good_frames_o, pred_res.good);
          check_field("bad_frames", bad_frames_o, pred_res.bad);
          check_field("angles_valid", 32'(angles_valid_o), 32'(pred_res.valid));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    hdr_cfg      = HEADER_RESET;
    type_cfg     = TYPE_RESET;
    frame_bytes  = '{default: 8'h00};
    bytes_held   = 0;
    held_roll    = '0;
    held_pitch   = '0;
    held_yaw     = '0;
    good_total   = '0;
    bad_total    = '0;
    angles_seen  = 1'b0;
    queued_total = 0;
    mismatches   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Repeated header, extreme angles, a restart, then a bad frame whose
    // pair near the end leaves a partial frame for the random part to finish.
    queue_byte(hdr_cfg);
    queue_frame(FRAME_GOOD, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
    queue_byte(hdr_cfg);
    queue_byte(~type_cfg);
    queue_frame(FRAME_BAD_RESYNC, 16'h0000, 16'h0001, 16'hFFFE, FRAME_LEN - 3);
    queue_random(380);

    start_phase(8'h00, 8'hFF, 250);
    wait_drained();
    write_reg(CFG_SPARE_2, 8'($urandom()));
    start_phase(8'hFF, 8'h00, 250);
    start_phase(8'hA5, 8'hA5, 250);
    start_phase(8'($urandom()), 8'($urandom()), 250);
    wait_drained();
    write_reg(CFG_SPARE_3, 8'($urandom()));
    start_phase(HEADER_RESET, TYPE_RESET, 200);
    wait_drained();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
